[rtl/polar_points_bounding_box_assert.svh]
// Assertion macros shared by the bounding box RTL.
// Both macros sample on the rising edge of clock and stand down while reset is high.
`ifndef POLAR_POINTS_BOUNDING_BOX_ASSERT_SVH
`define POLAR_POINTS_BOUNDING_BOX_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define PPBB_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check that cons holds in the cycle after ante.
`define PPBB_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/ppbb_pkg.sv]
package ppbb_pkg;

   // Angle arithmetic in Q9.7 degrees
   localparam int TURN    = 46080;
   localparam int QUARTER = 11520;
   localparam int EIGHTH  = 5760;

   // 1/K of the CORDIC gain in Q0.30
   localparam int KINV = 652032874;

   // Arctangent table size and index width
   localparam int ATAN_COUNT = 24;
   localparam int IDX_W      = 5;
   localparam int ATAN_W     = 22;

   typedef struct packed {
      logic signed [16:0] angle_deg;
      logic signed [23:0] radius;
      logic               last_point;
   } req_item_type;

   typedef struct packed {
      logic signed [23:0] min_x;
      logic signed [23:0] max_x;
      logic signed [23:0] min_y;
      logic signed [23:0] max_y;
   } rsp_item_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic             load;
      logic             start;
      logic             step;
      logic             fin;
      logic             update;
      logic             emit;
      logic [IDX_W-1:0] step_idx;
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic last_point;
   } stat_type;

   // atan(2^-i) in degrees, scaled by 2^16, rounded to nearest
   function automatic logic [ATAN_W-1:0] atan_lut(input logic [IDX_W-1:0] idx);
      logic [ATAN_W-1:0] v;
      case (idx)
         5'd0:    v = 22'd2949120;
         5'd1:    v = 22'd1740967;
         5'd2:    v = 22'd919879;
         5'd3:    v = 22'd466945;
         5'd4:    v = 22'd234379;
         5'd5:    v = 22'd117304;
         5'd6:    v = 22'd58666;
         5'd7:    v = 22'd29335;
         5'd8:    v = 22'd14668;
         5'd9:    v = 22'd7334;
         5'd10:   v = 22'd3667;
         5'd11:   v = 22'd1833;
         5'd12:   v = 22'd917;
         5'd13:   v = 22'd458;
         5'd14:   v = 22'd229;
         5'd15:   v = 22'd115;
         5'd16:   v = 22'd57;
         5'd17:   v = 22'd29;
         5'd18:   v = 22'd14;
         5'd19:   v = 22'd7;
         5'd20:   v = 22'd4;
         5'd21:   v = 22'd2;
         5'd22:   v = 22'd1;
         default: v = 22'd0;
      endcase
      return v;
   endfunction

endpackage

[rtl/ppbb_dpath.sv]
module ppbb_dpath (
   input  logic                   clock,
   input  logic                   reset,
   input  ppbb_pkg::cmd_type      cmd,
   input  ppbb_pkg::req_item_type req_item,
   output ppbb_pkg::stat_type     stat,
   output ppbb_pkg::rsp_item_type rsp_item
);

   localparam logic signed [18:0] TURN_W    = 19'(ppbb_pkg::TURN);
   localparam logic [15:0]        EIGHTH_W  = 16'(ppbb_pkg::EIGHTH);
   localparam logic [15:0]        QUARTER_W = 16'(ppbb_pkg::QUARTER);
   localparam logic signed [30:0] KINV_W    = 31'(ppbb_pkg::KINV);

   // Round to Q15.8 and clamp
   function automatic logic signed [23:0] finish(input logic signed [41:0] v);
      logic signed [41:0] s;
      logic signed [25:0] r;
      logic signed [23:0] o;
      s = v + 42'sd32768;
      r = s[41:16];
      if (r > 26'sd8388607) begin
         o = 24'sh7FFFFF;
      end else if (r < -26'sd8388608) begin
         o = 24'sh800000;
      end else begin
         o = r[23:0];
      end
      return o;
   endfunction

   logic signed [54:0] prod_ff, prod_in;
   logic        [1:0]  quad_ff, quad_in;
   logic signed [24:0] z_ff, z_in;
   logic               last_ff, last_in;
   logic signed [41:0] x_ff, x_in;
   logic signed [41:0] y_ff, y_in;
   logic signed [23:0] fx_ff, fx_in;
   logic signed [23:0] fy_ff, fy_in;
   logic signed [23:0] low_x_ff, low_x_in, high_x_ff, high_x_in;
   logic signed [23:0] low_y_ff, low_y_in, high_y_ff, high_y_in;
   logic               empty_ff, empty_in;
   ppbb_pkg::rsp_item_type rsp_item_ff, rsp_item_in;

   logic signed [18:0] ang_w;
   logic signed [18:0] mod_w;
   logic        [15:0] mod_u;
   logic signed [16:0] res_w;
   logic        [1:0]  quad_w;
   logic signed [54:0] rsum;
   logic signed [41:0] r0;
   logic signed [41:0] dx, dy;
   logic signed [24:0] atan_w;

   // Reduce the angle into one turn, then into a quadrant and a residual within an eighth turn
   always_comb begin
      ang_w = {{2{req_item.angle_deg[16]}}, req_item.angle_deg};
      if (ang_w < -TURN_W) begin
         mod_w = ang_w + (TURN_W <<< 1);
      end else if (ang_w < 19'sd0) begin
         mod_w = ang_w + TURN_W;
      end else if (ang_w >= TURN_W) begin
         mod_w = ang_w - TURN_W;
      end else begin
         mod_w = ang_w;
      end
      mod_u = mod_w[15:0];
      if (mod_u < EIGHTH_W) begin
         quad_w = 2'd0;
         res_w  = $signed({1'b0, mod_u});
      end else if (mod_u < EIGHTH_W + QUARTER_W) begin
         quad_w = 2'd1;
         res_w  = $signed({1'b0, mod_u}) - $signed({1'b0, QUARTER_W});
      end else if (mod_u < EIGHTH_W + (QUARTER_W << 1)) begin
         quad_w = 2'd2;
         res_w  = $signed({1'b0, mod_u}) - $signed({1'b0, QUARTER_W << 1});
      end else if (mod_u < EIGHTH_W + 16'(3 * ppbb_pkg::QUARTER)) begin
         quad_w = 2'd3;
         res_w  = $signed({1'b0, mod_u}) - $signed({1'b0, 16'(3 * ppbb_pkg::QUARTER)});
      end else begin
         quad_w = 2'd0;
         res_w  = $signed({1'b0, mod_u}) - $signed({1'b0, 16'(ppbb_pkg::TURN)});
      end
   end

   always_comb begin
      rsum   = prod_ff + 55'sd8192;
      r0     = {rsum[54], rsum[54:14]};
      dx     = y_ff >>> cmd.step_idx;
      dy     = x_ff >>> cmd.step_idx;
      atan_w = $signed({3'b000, ppbb_pkg::atan_lut(cmd.step_idx)});
   end

   always_comb begin
      prod_in = prod_ff;
      quad_in = quad_ff;
      z_in    = z_ff;
      last_in = last_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      fx_in   = fx_ff;
      fy_in   = fy_ff;
      if (cmd.load) begin
         prod_in = req_item.radius * KINV_W;
         quad_in = quad_w;
         z_in    = {{2{res_w[13]}}, res_w[13:0], 9'd0};
         last_in = req_item.last_point;
      end
      if (cmd.start) begin
         case (quad_in)
            2'd0: begin
               x_in = r0;
               y_in = '0;
            end
            2'd1: begin
               x_in = '0;
               y_in = r0;
            end
            2'd2: begin
               x_in = -r0;
               y_in = '0;
            end
            default: begin
               x_in = '0;
               y_in = -r0;
            end
         endcase
      end
      if (cmd.step) begin
         if (z_ff >= 25'sd0) begin
            x_in = x_ff - dx;
            y_in = y_ff + dy;
            z_in = z_ff - atan_w;
         end else begin
            x_in = x_ff + dx;
            y_in = y_ff - dy;
            z_in = z_ff + atan_w;
         end
      end
      if (cmd.fin) begin
         fx_in = finish(x_ff);
         fy_in = finish(y_ff);
      end
   end

   // Fold the point into the box; an empty set takes the point as its box
   always_comb begin
      low_x_in    = low_x_ff;
      high_x_in   = high_x_ff;
      low_y_in    = low_y_ff;
      high_y_in   = high_y_ff;
      empty_in    = empty_ff;
      rsp_item_in = rsp_item_ff;
      if (cmd.update) begin
         if (empty_ff) begin
            low_x_in  = fx_ff;
            high_x_in = fx_ff;
            low_y_in  = fy_ff;
            high_y_in = fy_ff;
         end else begin
            if (fx_ff < low_x_ff)  low_x_in  = fx_ff;
            if (fx_ff > high_x_ff) high_x_in = fx_ff;
            if (fy_ff < low_y_ff)  low_y_in  = fy_ff;
            if (fy_ff > high_y_ff) high_y_in = fy_ff;
         end
         empty_in = last_ff;
      end
      if (cmd.emit) begin
         rsp_item_in.min_x = low_x_in;
         rsp_item_in.max_x = high_x_in;
         rsp_item_in.min_y = low_y_in;
         rsp_item_in.max_y = high_y_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff     <= prod_in;
      quad_ff     <= quad_in;
      z_ff        <= z_in;
      last_ff     <= last_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      fx_ff       <= fx_in;
      fy_ff       <= fy_in;
      low_x_ff    <= low_x_in;
      high_x_ff   <= high_x_in;
      low_y_ff    <= low_y_in;
      high_y_ff   <= high_y_in;
      rsp_item_ff <= rsp_item_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         empty_ff <= 1'b1;
      end else begin
         empty_ff <= empty_in;
      end
   end

   assign stat.last_point = last_ff;
   assign rsp_item        = rsp_item_ff;

endmodule

[rtl/ppbb_ctrl.sv]
`include "polar_points_bounding_box_assert.svh"

module ppbb_ctrl #(
   parameter int CORDIC_STAGES = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   input  ppbb_pkg::stat_type stat,
   output ppbb_pkg::cmd_type  cmd
);

   localparam int IW = ppbb_pkg::IDX_W;
   localparam int STAGES_EFF =
      (CORDIC_STAGES > ppbb_pkg::ATAN_COUNT) ? ppbb_pkg::ATAN_COUNT : CORDIC_STAGES;
   localparam logic [IW-1:0] LAST_IDX = IW'(STAGES_EFF - 1);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_START = 3'd1;
   localparam logic [2:0] S_ROT   = 3'd2;
   localparam logic [2:0] S_FIN   = 3'd3;
   localparam logic [2:0] S_UPD   = 3'd4;

   logic [2:0]    state_ff, state_in;
   logic [IW-1:0] cnt_ff, cnt_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      cmd          = '0;
      cmd.step_idx = cnt_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_START;
            end
         end
         S_START: begin
            cmd.start = 1'b1;
            cnt_in    = '0;
            state_in  = S_ROT;
         end
         S_ROT: begin
            cmd.step = 1'b1;
            if (cnt_ff == LAST_IDX) begin
               state_in = S_FIN;
            end else begin
               cnt_in = cnt_ff + IW'(1);
            end
         end
         S_FIN: begin
            cmd.fin  = 1'b1;
            state_in = S_UPD;
         end
         S_UPD: begin
            // Hold a last point until the output register can take its box
            if (!stat.last_point || out_free) begin
               cmd.update = 1'b1;
               cmd.emit   = stat.last_point;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `PPBB_ASSERT_NEXT(a_accept_starts, req_valid && req_ready, state_ff == S_START, "accepted item did not start")
   `PPBB_ASSERT_NEXT(a_rot_exits, (state_ff == S_ROT) && (cnt_ff == LAST_IDX), state_ff == S_FIN, "rotation overran its stage count")
   `PPBB_ASSERT_NOW(a_emit_free, cmd.emit, !rsp_valid_ff || rsp_ready, "box emitted over a pending result")
   `PPBB_ASSERT_NEXT(a_emit_valid, cmd.emit, rsp_valid_ff, "emitted box not presented")

endmodule

[rtl/polar_points_bounding_box.sv]
// Points go one at a time; a new one is accepted only after the last has passed through
//   load, start, the shared CORDIC stage iterating once per cycle, round and update.
// Result: the last point's update waits for a free output and registers box and rsp_valid.
// Reset: synchronous, active high; clears the controller, the output valid and marks the set
//   empty. Box and datapath registers hold no reset value.
module polar_points_bounding_box #(
   parameter int CORDIC_STAGES = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  ppbb_pkg::req_item_type req_item,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output ppbb_pkg::rsp_item_type rsp_item
);

   // Controller sequences one point at a time: accept, quarter-turn start, the CORDIC
   // iterations, rounding to Q15.8, then the box update.
   ppbb_pkg::cmd_type  cmd;
   ppbb_pkg::stat_type stat;

   // Drive the sequence and own both handshakes
   ppbb_ctrl #(
      .CORDIC_STAGES(CORDIC_STAGES)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Angle reduction, gain-corrected radius, rotation, rounding and the running box;
   // the output item register lets the next point start while a box waits to be taken
   ppbb_dpath u_dpath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_item (req_item),
      .stat     (stat),
      .rsp_item (rsp_item)
   );

endmodule
